### hdl/polyphase_rational_resampler_assert.svh
// assertion macros for the resampler, clocked on clk, held off while rst_n is low
`ifndef POLYPHASE_RATIONAL_RESAMPLER_ASSERT_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_ASSERT_SVH

// same-cycle implication
`define RSM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler check failed");

// next-cycle implication
`define RSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler check failed");

`endif

### hdl/rsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsm_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = SAMPLE_BITS - 1;
  localparam int COEF_IDX_BITS = 8;
  localparam int REG_BITS      = 5;
  localparam int PEND_BITS     = 5;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_RATIO_UP    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATIO_DOWN  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAPS_IN_USE = 2'd2;

  localparam logic [REG_BITS-1:0]  RESET_RATIO   = 5'd1;
  localparam logic [REG_BITS-1:0]  RESET_TAPS    = 5'd8;
  localparam logic [PEND_BITS-1:0] RESET_PENDING = 5'd8;

  typedef struct packed {
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [COEF_IDX_BITS-1:0]      coef_index;
    logic signed [SAMPLE_BITS-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_STEP,
    S_EMIT,
    S_PASS
  } state_t;

  // tags travelling alongside one memory read into the multiply-accumulate
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

### hdl/rsm_coef_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rsm_coef_ram #(
  parameter int DEPTH     = 256,
  parameter int DATA_BITS = 16,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/rsm_window.sv
`timescale 1ns / 1ps
`default_nettype none

// circular sample window; entries never written since reset read as zero
module rsm_window #(
  parameter int MAX_TAPS  = 16,
  parameter int PTR_BITS  = $clog2(MAX_TAPS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                wr_en,
  input  wire logic [rsm_pkg::SAMPLE_BITS-1:0]     wr_data,
  output logic      [PTR_BITS-1:0]                 newest,
  input  wire logic [PTR_BITS-1:0]                 rd_addr,
  output logic      [rsm_pkg::SAMPLE_BITS-1:0]     rd_data
);

  logic [rsm_pkg::SAMPLE_BITS-1:0] mem_r [MAX_TAPS];
  logic [rsm_pkg::SAMPLE_BITS-1:0] rd_data_r;
  logic [MAX_TAPS-1:0]             valid_r, valid_nxt;
  logic [PTR_BITS-1:0]             newest_r, newest_nxt;

  always_comb begin
    newest_nxt = newest_r;
    valid_nxt  = valid_r;
    if (wr_en) begin
      newest_nxt = (32'(newest_r) == MAX_TAPS - 1) ? '0 : newest_r + 1'b1;
      valid_nxt[newest_nxt] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r <= '0;
      valid_r  <= '0;
    end else begin
      newest_r <= newest_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[newest_nxt] <= wr_data;
    end
    rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
  end

  assign newest  = newest_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/rsm_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// registered product, accumulator, then round half up and saturate
module rsm_mac #(
  parameter int MAX_TAPS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire rsm_pkg::mac_ctl_t                      ctl,
  input  wire logic signed [rsm_pkg::SAMPLE_BITS-1:0] coef,
  input  wire logic signed [rsm_pkg::SAMPLE_BITS-1:0] samp,
  output logic                                        done,
  output logic signed      [rsm_pkg::SAMPLE_BITS-1:0] result
);

  localparam int SB   = rsm_pkg::SAMPLE_BITS;
  localparam int FB   = rsm_pkg::FRAC_BITS;
  localparam int PB   = 2 * SB;
  localparam int AB   = PB + $clog2(MAX_TAPS) + 1;
  localparam int RB   = AB + 1 - FB;
  localparam logic signed [AB:0] HALF = (AB + 1)'(1) <<< (FB - 1);

  logic signed [PB-1:0] prod_r;
  rsm_pkg::mac_ctl_t    prod_ctl_r;
  logic signed [AB-1:0] acc_r;
  logic                 done_r;
  logic signed [AB:0]   rnd;
  logic signed [RB-1:0] shr;
  logic                 fits;

  always_ff @(posedge clk) begin
    prod_r <= coef * samp;
    if (prod_ctl_r.valid) begin
      acc_r <= prod_ctl_r.first ? AB'(prod_r) : acc_r + AB'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_ctl_r <= '0;
      done_r     <= 1'b0;
    end else begin
      prod_ctl_r <= ctl;
      done_r     <= prod_ctl_r.valid && prod_ctl_r.last;
    end
  end

  always_comb begin
    rnd  = {acc_r[AB-1], acc_r} + HALF;
    shr  = rnd[AB:FB];
    fits = (&shr[RB-1:SB-1]) || !(|shr[RB-1:SB-1]);
    if (fits) begin
      result = shr[SB-1:0];
    end else if (shr[RB-1]) begin
      result = {1'b1, {(SB-1){1'b0}}};
    end else begin
      result = {1'b0, {(SB-1){1'b1}}};
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

### hdl/polyphase_rational_resampler.sv
// Polyphase rational resampler: changes the sample rate by ratio_up/ratio_down
// through a bank of FIR branches held in a coefficient memory (slot = branch *
// MAX_TAPS + tap, loaded by func = 1 items, which give no result) against a
// circular window memory of the latest samples. Each sample item shifts into
// the window; an output falls due whenever the pending count reaches zero, and
// every output is the Q1.15 dot product of the current branch with the newest
// taps_in_use samples, rounded half up and saturated. With up = down = 1 the
// sample passes straight through the pass state into the output register. A
// sample item that gives no output is taken without leaving the idle state;
// each output takes a load step, taps_in_use reads into the single shared
// multiply-accumulate, a drain wait for the memory and multiplier pipeline,
// the branch stepper, where carry = (branch + down) / up is worked out by
// repeated subtraction, and an emit step that waits out any output stall.
// The window clears by valid bits at reset, so there is no clearing pass;
// the coefficient table is not cleared and must be loaded before use. New
// items are stalled until the last output of the current item sits in the
// output register. Configuration is taken every cycle; the user must keep it
// to idle time only, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "polyphase_rational_resampler_assert.svh"

module polyphase_rational_resampler #(
  parameter int MAX_RATIO = 16,
  parameter int MAX_TAPS  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // item input
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire rsm_pkg::in_item_t                   in_item,
  // result output
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rsm_pkg::out_item_t                       out_item,
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rsm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [rsm_pkg::REG_BITS-1:0]        cfg_data
);

  localparam int SB         = rsm_pkg::SAMPLE_BITS;
  localparam int RGB        = rsm_pkg::REG_BITS;
  localparam int PDB        = rsm_pkg::PEND_BITS;
  localparam int BR_W       = $clog2(MAX_RATIO);
  localparam int SUM_W      = $clog2(2 * MAX_RATIO);
  localparam int TP_W       = $clog2(MAX_TAPS);
  localparam int CNT_W      = $clog2(MAX_RATIO + 1);
  localparam int TABLE_SIZE = MAX_RATIO * MAX_TAPS;
  localparam int CA_W       = $clog2(TABLE_SIZE);

  // clamp a register to its usable range
  function automatic logic [RGB-1:0] clamp_reg(input logic [RGB-1:0] v,
                                               input int lo, input int hi);
    logic [RGB-1:0] r;
    if (32'(v) < lo) begin
      r = RGB'(lo);
    end else if (32'(v) > hi) begin
      r = RGB'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  rsm_pkg::state_t      state_r, state_nxt;
  logic [RGB-1:0]       up_r, up_nxt;
  logic [RGB-1:0]       down_r, down_nxt;
  logic [RGB-1:0]       taps_r, taps_nxt;
  logic [BR_W-1:0]      branch_r, branch_nxt;
  logic [PDB-1:0]       pend_r, pend_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TP_W-1:0]      tap_r, tap_nxt;
  logic [TP_W-1:0]      rdp_r, rdp_nxt;
  logic [SUM_W-1:0]     rem_r, rem_nxt;
  logic [SB-1:0]        pass_r, pass_nxt;
  rsm_pkg::mac_ctl_t    issue_ctl_r, issue_ctl;
  logic                 out_valid_r, out_valid_nxt;
  rsm_pkg::out_item_t   out_item_r, out_item_nxt;

  // effective register values
  logic [RGB-1:0]       up_eff, down_eff, taps_eff;
  logic                 pass_mode;

  logic                 in_acc, is_sample, is_coef, coef_wr;
  logic [PDB-1:0]       pend_dec;
  logic                 slot_free, issue_last, emit_last, step_sub, out_load;
  logic [TP_W-1:0]      win_start, rdp_inc, newest;
  logic [CA_W-1:0]      coef_rd_addr, coef_wr_addr;
  logic [SB-1:0]        coef_rd_data, win_rd_data;
  logic                 mac_done;
  logic signed [SB-1:0] mac_result;

  assign up_eff    = clamp_reg(up_r, 1, MAX_RATIO);
  assign down_eff  = clamp_reg(down_r, 1, MAX_RATIO);
  assign taps_eff  = clamp_reg(taps_r, 2, MAX_TAPS);
  assign pass_mode = (up_eff == RGB'(1)) && (down_eff == RGB'(1));

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign is_sample = in_acc && (in_item.func == rsm_pkg::FUNC_SAMPLE);
  assign is_coef   = in_acc && (in_item.func == rsm_pkg::FUNC_COEF);
  assign coef_wr   = is_coef && (32'(in_item.coef_index) < TABLE_SIZE);

  assign pend_dec   = pend_r - PDB'(pend_r != '0);
  assign slot_free  = !out_valid_r || !out_stall;
  assign issue_last = (32'(tap_r) == 32'(taps_eff) - 1);
  // last output of the item: no more due, or the per-item cap is reached
  assign emit_last  = (pend_r != '0) || (32'(cnt_r) + 1 == MAX_RATIO);
  assign step_sub   = (32'(rem_r) >= 32'(up_eff));

  // tap 0 meets the oldest sample of the window
  always_comb begin
    if (32'(newest) >= 32'(taps_eff) - 1) begin
      win_start = TP_W'(32'(newest) - (32'(taps_eff) - 1));
    end else begin
      win_start = TP_W'(32'(newest) + MAX_TAPS - (32'(taps_eff) - 1));
    end
  end

  assign rdp_inc      = (32'(rdp_r) == MAX_TAPS - 1) ? '0 : rdp_r + 1'b1;
  assign coef_rd_addr = CA_W'(32'(branch_r) * MAX_TAPS + 32'(tap_r));
  assign coef_wr_addr = CA_W'(32'(in_item.coef_index));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsm_pkg::S_IDLE: begin
        if (is_sample) begin
          if (pass_mode) begin
            state_nxt = rsm_pkg::S_PASS;
          end else if (pend_dec == '0) begin
            state_nxt = rsm_pkg::S_LOAD;
          end
        end
      end
      rsm_pkg::S_LOAD: begin
        state_nxt = rsm_pkg::S_MAC;
      end
      rsm_pkg::S_MAC: begin
        if (issue_last) begin
          state_nxt = rsm_pkg::S_DRAIN;
        end
      end
      rsm_pkg::S_DRAIN: begin
        if (mac_done) begin
          state_nxt = rsm_pkg::S_STEP;
        end
      end
      rsm_pkg::S_STEP: begin
        if (!step_sub) begin
          state_nxt = rsm_pkg::S_EMIT;
        end
      end
      rsm_pkg::S_EMIT: begin
        if (slot_free) begin
          state_nxt = emit_last ? rsm_pkg::S_IDLE : rsm_pkg::S_LOAD;
        end
      end
      rsm_pkg::S_PASS: begin
        if (slot_free) begin
          state_nxt = rsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rsm_pkg::S_IDLE;
      end
    endcase
  end

  // state-driven controls
  always_comb begin
    in_stall        = (state_r != rsm_pkg::S_IDLE);
    issue_ctl.valid = (state_r == rsm_pkg::S_MAC);
    issue_ctl.first = (tap_r == '0);
    issue_ctl.last  = issue_last;
    out_load        = ((state_r == rsm_pkg::S_EMIT) || (state_r == rsm_pkg::S_PASS))
                      && slot_free;
  end

  // datapath registers
  always_comb begin
    up_nxt     = up_r;
    down_nxt   = down_r;
    taps_nxt   = taps_r;
    branch_nxt = branch_r;
    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    tap_nxt    = tap_r;
    rdp_nxt    = rdp_r;
    rem_nxt    = rem_r;
    pass_nxt   = pass_r;

    // writing either ratio restarts the branch sequence
    if (cfg_valid) begin
      case (cfg_index)
        rsm_pkg::REG_RATIO_UP: begin
          up_nxt     = cfg_data;
          branch_nxt = '0;
        end
        rsm_pkg::REG_RATIO_DOWN: begin
          down_nxt   = cfg_data;
          branch_nxt = '0;
        end
        rsm_pkg::REG_TAPS_IN_USE: begin
          taps_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      rsm_pkg::S_IDLE: begin
        if (is_sample) begin
          pass_nxt = in_item.sample_in;
          cnt_nxt  = '0;
          // pass-through leaves branch and pending count alone
          if (!pass_mode) begin
            pend_nxt = pend_dec;
            if (32'(branch_r) >= 32'(up_eff)) begin
              branch_nxt = '0;
            end
          end
        end
      end
      rsm_pkg::S_LOAD: begin
        tap_nxt = '0;
        rdp_nxt = win_start;
      end
      rsm_pkg::S_MAC: begin
        tap_nxt = tap_r + 1'b1;
        rdp_nxt = rdp_inc;
      end
      rsm_pkg::S_DRAIN: begin
        if (mac_done) begin
          rem_nxt = SUM_W'(branch_r) + SUM_W'(down_eff);
        end
      end
      rsm_pkg::S_STEP: begin
        // one subtraction of up per cycle, each one a carry into pending
        if (step_sub) begin
          rem_nxt  = rem_r - SUM_W'(up_eff);
          pend_nxt = pend_r + 1'b1;
        end else begin
          branch_nxt = BR_W'(rem_r);
        end
      end
      rsm_pkg::S_EMIT: begin
        if (slot_free) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (state_r == rsm_pkg::S_PASS) begin
        out_item_nxt.sample_out = pass_r;
        out_item_nxt.last       = 1'b1;
      end else begin
        out_item_nxt.sample_out = mac_result;
        out_item_nxt.last       = emit_last;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsm_pkg::S_IDLE;
      up_r        <= rsm_pkg::RESET_RATIO;
      down_r      <= rsm_pkg::RESET_RATIO;
      taps_r      <= rsm_pkg::RESET_TAPS;
      branch_r    <= '0;
      pend_r      <= rsm_pkg::RESET_PENDING;
      cnt_r       <= '0;
      issue_ctl_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
      taps_r      <= taps_nxt;
      branch_r    <= branch_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      issue_ctl_r <= issue_ctl;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tap_r      <= tap_nxt;
    rdp_r      <= rdp_nxt;
    rem_r      <= rem_nxt;
    pass_r     <= pass_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  rsm_coef_ram #(
    .DEPTH     (TABLE_SIZE),
    .DATA_BITS (SB)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (coef_wr_addr),
    .wr_data (in_item.coef_value),
    .rd_addr (coef_rd_addr),
    .rd_data (coef_rd_data)
  );

  rsm_window #(
    .MAX_TAPS (MAX_TAPS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (is_sample),
    .wr_data (in_item.sample_in),
    .newest  (newest),
    .rd_addr (rdp_r),
    .rd_data (win_rd_data)
  );

  // read tags are registered once so that they line up with the registered memory data
  rsm_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (issue_ctl_r),
    .coef   (coef_rd_data),
    .samp   (win_rd_data),
    .done   (mac_done),
    .result (mac_result)
  );

  // a finished sum only turns up while the sequencer waits for it
  `RSM_ASSERT_IMPLY(a_done_in_drain, mac_done, state_r == rsm_pkg::S_DRAIN)
  // branch always addresses a live polyphase branch
  `RSM_ASSERT_IMPLY(a_branch_live, 1'b1, 32'(branch_r) < 32'(up_eff))
  // an emitted result lands in the output register
  `RSM_ASSERT_NEXT(a_emit_loads, out_load, out_valid_r)
  // no item gives more than the per-item cap of results
  `RSM_ASSERT_IMPLY(a_count_cap, state_r == rsm_pkg::S_EMIT, 32'(cnt_r) < MAX_RATIO)

endmodule

`default_nettype wire
